// ===== hdl/ces_pkg.sv =====
// Package with the word types and status codes of the countdown event scheduler.
package ces_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int FIRED_W     = $clog2(MAX_RESULTS + 1);

	localparam logic KIND_SCHED = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	localparam logic [1:0] ST_SCHED_OK = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_FIRED    = 2'd2;
	localparam logic [1:0] ST_NONE     = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [15:0] delay_ticks;
		logic [7:0]  event_id;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  fired_id;
		logic [15:0] cycle_count;
		logic        last;
	} res_word_t;

	typedef struct packed {
		logic [15:0] ticks;
		logic [7:0]  id;
	} entry_t;

endpackage

// ===== hdl/countdown_event_scheduler.sv =====
// Top level of the countdown event scheduler: event table, walk sequencer and result register.
// A schedule word is answered in the cycle after it is accepted, and busy stays low.
// A tick word walks the table through one memory read port, one entry per cycle:
// busy is high through the walk and the flush state, or not at all when the table is empty.
// Results leave as one-cycle strobes; the closing word comes in the same cycle that busy falls.
// Reset clears the entry count, the tick counter and the sequencer; table contents stay undefined.
module countdown_event_scheduler
	import ces_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cmd_word_t cmd,
	output logic      res_valid,
	output res_word_t res
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [1:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [15:0]        tick_q;
	logic [AW-1:0]      rd_q;
	logic [CW-1:0]      wr_q;
	logic [FIRED_W-1:0] fired_q;
	logic               held_v_q;
	logic [7:0]         held_id_q;
	logic               res_valid_q;
	res_word_t          res_q;

	entry_t             mem [TABLE_DEPTH];
	entry_t             rdata_q;
	logic [AW-1:0]      rd_addr;
	logic               we;
	logic [AW-1:0]      waddr;
	entry_t             wdata;

	logic               accept;
	logic               fire;
	logic               walk_end;
	logic [15:0]        next_ticks;

	assign accept     = start && (state_q == S_IDLE);
	assign fire       = (rdata_q.ticks == 16'd0) && (fired_q < FIRED_W'(MAX_RESULTS));
	assign walk_end   = (CW'(rd_q) == count_q - CW'(1));
	assign next_ticks = (rdata_q.ticks != 16'd0) ? rdata_q.ticks - 16'd1 : rdata_q.ticks;

	always_comb begin
		rd_addr = (state_q == S_WALK) ? rd_q + AW'(1) : '0;
		we      = 1'b0;
		waddr   = count_q[AW-1:0];
		wdata   = '{ticks: cmd.delay_ticks, id: cmd.event_id};
		if (accept && cmd.kind == KIND_SCHED && cmd.event_id != 8'd0
				&& count_q != CW'(TABLE_DEPTH)) begin
			we = 1'b1;
		end else if (state_q == S_WALK && !fire) begin
			we    = 1'b1;
			waddr = wr_q[AW-1:0];
			wdata = '{ticks: next_ticks, id: rdata_q.id};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			tick_q      <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			fired_q     <= '0;
			held_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_valid_q <= 1'b1;
						res_q.fired_id <= 8'd0;
						res_q.last     <= 1'b1;
						if (cmd.kind == KIND_SCHED) begin
							res_q.cycle_count <= tick_q;
							if (cmd.event_id == 8'd0) begin
								res_q.status <= ST_SCHED_OK;
							end else if (count_q == CW'(TABLE_DEPTH)) begin
								res_q.status <= ST_FULL;
							end else begin
								res_q.status <= ST_SCHED_OK;
								count_q      <= count_q + CW'(1);
							end
						end else begin
							tick_q            <= tick_q + 16'd1;
							res_q.cycle_count <= tick_q + 16'd1;
							res_q.status      <= ST_NONE;
							rd_q              <= '0;
							wr_q              <= '0;
							fired_q           <= '0;
							held_v_q          <= 1'b0;
							if (count_q != '0) begin
								res_valid_q <= 1'b0;
								state_q     <= S_WALK;
							end
						end
					end
				end
				S_WALK: begin
					if (fire) begin
						fired_q   <= fired_q + FIRED_W'(1);
						held_v_q  <= 1'b1;
						held_id_q <= rdata_q.id;
						if (held_v_q) begin
							res_valid_q <= 1'b1;
							res_q <= '{status: ST_FIRED, fired_id: held_id_q,
								cycle_count: tick_q, last: 1'b0};
						end
					end else begin
						wr_q <= wr_q + CW'(1);
					end
					rd_q <= rd_q + AW'(1);
					if (walk_end) begin
						count_q <= fire ? wr_q : wr_q + CW'(1);
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					res_valid_q <= 1'b1;
					if (held_v_q) begin
						res_q <= '{status: ST_FIRED, fired_id: held_id_q,
							cycle_count: tick_q, last: 1'b1};
					end else begin
						res_q <= '{status: ST_NONE, fired_id: 8'd0,
							cycle_count: tick_q, last: 1'b1};
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hdl/ces_checker.sv =====
// Port checker for the countdown event scheduler and its bind to the top level.
module ces_checker
	import ces_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input cmd_word_t cmd,
	input logic      res_valid,
	input res_word_t res
);

	// A word that is not a firing always closes its command.
	a_nonfire_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_FIRED |-> res.last)
		else $error("non-fired result without last");

	a_nonfire_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_FIRED |-> res.fired_id == 8'd0)
		else $error("non-fired result with nonzero id");

	a_sched_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == KIND_SCHED |=> res_valid && res.last && !busy)
		else $error("schedule word not answered in the next cycle");

	// Further firings can only follow while the walk is still running.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> busy)
		else $error("result without last while idle");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == KIND_TICK |=> busy || (res_valid && res.status == ST_NONE))
		else $error("tick neither walks nor answers quietly");

endmodule

bind countdown_event_scheduler ces_checker u_ces_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res       (res)
);
